// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rstn is low
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while rstn is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/dwcc_pkg.sv =====
// package: sizes, item codes and row types of the depthwise causal filter
package dwcc_pkg;

    // filter geometry
    localparam int CHANNELS = 32;
    localparam int TAPS     = 4;
    localparam int HIST_LEN = TAPS - 1;

    // memory address width
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // fixed field widths
    localparam int KIND_W = 2;
    localparam int CH_W   = 5;
    localparam int TAP_W  = 2;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    // rounding and saturation of the Q16.16 sum to Q8.8
    localparam int FRAC_SHIFT = 8;
    localparam int ROUND_ADD  = 128;
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef logic [CH_AW-1:0]                 ch_addr_t;
    typedef logic [HIST_LEN-1:0][VAL_W-1:0]   hist_row_t;
    typedef logic [TAPS-1:0][VAL_W-1:0]       wgt_row_t;
    typedef logic [TAPS-1:0]                  tap_mask_t;

endpackage

// ===== rtl/depthwise_causal_conv1d.sv =====
// Depthwise causal FIR filter: a sample passes the stage 1 and stage 2 registers into the
// result register. Each channel keeps TAPS Q8.8 weights in a weight memory and its last
// TAPS-1 samples in a history memory, one row per channel, both read into stage 1 registers.
// A load request writes one weight lane, a clear request zeroes the channel's history,
// a sample request reads both rows, multiplies all taps in parallel, writes the shifted
// history back and yields one rounded, saturated Q8.8 result with a clip flag.
// Sustained rate is one request per cycle while the result channel is not stalled: the
// read-modify-write of one row overlaps the read of the next request through a one-entry
// write bypass. History rows start at zero through per-row valid flags, so no clearing pass
// follows reset. Weights are undefined until loaded. Requests with an unused kind or an
// out-of-range channel, and loads with an out-of-range tap, are dropped on accept.
module depthwise_causal_conv1d (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dwcc_pkg::KIND_W-1:0] s_kind,
    input  logic [dwcc_pkg::CH_W-1:0]   s_channel,
    input  logic [dwcc_pkg::TAP_W-1:0]  s_tap,
    input  logic signed [dwcc_pkg::VAL_W-1:0] s_value,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dwcc_pkg::CH_W-1:0]   m_out_channel,
    output logic signed [dwcc_pkg::VAL_W-1:0] m_filtered,
    output logic                        m_clipped
);

    // memories
    dwcc_pkg::hist_row_t hist_mem [dwcc_pkg::CHANNELS];
    dwcc_pkg::wgt_row_t  wgt_mem  [dwcc_pkg::CHANNELS];

    // pipeline enables
    logic en0, en1, en2;

    // stage 1 registers
    logic                         s1_valid_reg, s1_valid_next;
    logic [dwcc_pkg::KIND_W-1:0]  s1_kind_reg;
    logic [dwcc_pkg::CH_W-1:0]    s1_ch_reg;
    dwcc_pkg::tap_mask_t          s1_mask_reg;
    logic signed [dwcc_pkg::VAL_W-1:0] s1_value_reg;
    dwcc_pkg::hist_row_t          hist_rd_reg;
    dwcc_pkg::wgt_row_t           wgt_rd_reg;

    // newest write, for the bypass
    logic                         lw_valid_reg;
    dwcc_pkg::ch_addr_t           lw_addr_reg;
    logic                         lw_hist_we_reg;
    dwcc_pkg::hist_row_t          lw_hist_reg;
    dwcc_pkg::tap_mask_t          lw_mask_reg;
    logic signed [dwcc_pkg::VAL_W-1:0] lw_wdata_reg;

    // history valid flags
    logic [dwcc_pkg::CHANNELS-1:0] hist_ok_reg;

    // stage 2 registers
    logic                         s2_valid_reg, s2_valid_next;
    logic [dwcc_pkg::CH_W-1:0]    s2_ch_reg;
    logic signed [dwcc_pkg::PROD_W-1:0] s2_prod_reg [dwcc_pkg::TAPS];

    // output registers
    logic                         m_valid_reg;
    logic [dwcc_pkg::CH_W-1:0]    m_out_channel_reg;
    logic signed [dwcc_pkg::VAL_W-1:0] m_filtered_reg;
    logic                         m_clipped_reg;

    // stage 0 signals
    dwcc_pkg::ch_addr_t  rd_addr;
    dwcc_pkg::tap_mask_t in_mask;
    logic                in_ok;

    // stage 1 signals
    dwcc_pkg::ch_addr_t  s1_addr;
    logic                lw_hit;
    logic                s1_sample, s1_load, s1_clear;
    logic                wr_fire, hist_we;
    dwcc_pkg::hist_row_t hist_cur, hist_new;
    dwcc_pkg::wgt_row_t  wgt_cur;
    logic signed [dwcc_pkg::PROD_W-1:0] prod [dwcc_pkg::TAPS];

    // stage 2 signals
    logic signed [dwcc_pkg::ACC_W-1:0] acc, acc_rnd, acc_q;
    logic signed [dwcc_pkg::VAL_W-1:0] res_sat;
    logic                              res_clip;

    // handshake enables, bubbles collapse toward the output
    assign en2     = !m_valid_reg || m_ready;
    assign en1     = !s2_valid_reg || en2;
    assign en0     = !s1_valid_reg || en1;
    assign s_ready = en0;

    // request decode
    always_comb begin
        rd_addr = dwcc_pkg::ch_addr_t'(s_channel);
        for (int t = 0; t < dwcc_pkg::TAPS; t++) begin
            in_mask[t] = (32'(s_tap) == t);
        end
        in_ok = (32'(s_channel) < dwcc_pkg::CHANNELS) &&
                ((s_kind == dwcc_pkg::KIND_SAMPLE) || (s_kind == dwcc_pkg::KIND_CLEAR) ||
                 ((s_kind == dwcc_pkg::KIND_LOAD) && (32'(s_tap) < dwcc_pkg::TAPS)));
        s1_valid_next = s1_valid_reg;
        if (en0) begin
            s1_valid_next = s_valid && in_ok;
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // stage 1 payload and memory reads
    always_ff @(posedge aclk) begin
        if (en0) begin
            s1_kind_reg  <= s_kind;
            s1_ch_reg    <= s_channel;
            s1_mask_reg  <= in_mask;
            s1_value_reg <= s_value;
            hist_rd_reg  <= hist_mem[rd_addr];
            wgt_rd_reg   <= wgt_mem[rd_addr];
        end
    end

    // bypass, history update and products
    always_comb begin
        s1_addr   = dwcc_pkg::ch_addr_t'(s1_ch_reg);
        s1_sample = (s1_kind_reg == dwcc_pkg::KIND_SAMPLE);
        s1_load   = (s1_kind_reg == dwcc_pkg::KIND_LOAD);
        s1_clear  = (s1_kind_reg == dwcc_pkg::KIND_CLEAR);
        wr_fire   = s1_valid_reg && en1;
        hist_we   = s1_sample || s1_clear;
        lw_hit    = lw_valid_reg && (lw_addr_reg == s1_addr);

        if (lw_hit && lw_hist_we_reg) begin
            hist_cur = lw_hist_reg;
        end else if (hist_ok_reg[s1_addr]) begin
            hist_cur = hist_rd_reg;
        end else begin
            hist_cur = '0;
        end

        for (int t = 0; t < dwcc_pkg::TAPS; t++) begin
            wgt_cur[t] = (lw_hit && lw_mask_reg[t]) ? lw_wdata_reg : wgt_rd_reg[t];
        end

        // shift the window, newest sample enters the last slot
        for (int t = 0; t < dwcc_pkg::HIST_LEN - 1; t++) begin
            hist_new[t] = hist_cur[t + 1];
        end
        hist_new[dwcc_pkg::HIST_LEN-1] = s1_value_reg;
        if (s1_clear) begin
            hist_new = '0;
        end

        for (int t = 0; t < dwcc_pkg::HIST_LEN; t++) begin
            prod[t] = $signed(hist_cur[t]) * $signed(wgt_cur[t]);
        end
        prod[dwcc_pkg::TAPS-1] = s1_value_reg * $signed(wgt_cur[dwcc_pkg::TAPS-1]);
    end

    // memory writes
    always_ff @(posedge aclk) begin
        if (wr_fire && hist_we) begin
            hist_mem[s1_addr] <= hist_new;
        end
        for (int t = 0; t < dwcc_pkg::TAPS; t++) begin
            if (wr_fire && s1_load && s1_mask_reg[t]) begin
                wgt_mem[s1_addr][t] <= s1_value_reg;
            end
        end
    end

    // history valid flags and bypass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_ok_reg  <= '0;
            lw_valid_reg <= 1'b0;
        end else if (wr_fire) begin
            lw_valid_reg <= 1'b1;
            if (hist_we) begin
                hist_ok_reg[s1_addr] <= 1'b1;
            end
        end
    end

    // bypass payload
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            lw_addr_reg    <= s1_addr;
            lw_hist_we_reg <= hist_we;
            lw_hist_reg    <= hist_new;
            lw_mask_reg    <= s1_load ? s1_mask_reg : '0;
            lw_wdata_reg   <= s1_value_reg;
        end
    end

    // stage 2 control
    always_comb begin
        s2_valid_next = s2_valid_reg;
        if (en1) begin
            s2_valid_next = s1_valid_reg && s1_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    // stage 2 payload
    always_ff @(posedge aclk) begin
        if (en1) begin
            s2_ch_reg <= s1_ch_reg;
            for (int t = 0; t < dwcc_pkg::TAPS; t++) begin
                s2_prod_reg[t] <= prod[t];
            end
        end
    end

    // sum, round half up, saturate
    always_comb begin
        acc = '0;
        for (int t = 0; t < dwcc_pkg::TAPS; t++) begin
            acc = acc + dwcc_pkg::ACC_W'(s2_prod_reg[t]);
        end
        acc_rnd = acc + dwcc_pkg::ACC_W'(dwcc_pkg::ROUND_ADD);
        acc_q   = acc_rnd >>> dwcc_pkg::FRAC_SHIFT;
        if (acc_q > dwcc_pkg::SAT_MAX) begin
            res_sat  = dwcc_pkg::VAL_W'(dwcc_pkg::SAT_MAX);
            res_clip = 1'b1;
        end else if (acc_q < dwcc_pkg::SAT_MIN) begin
            res_sat  = dwcc_pkg::VAL_W'(dwcc_pkg::SAT_MIN);
            res_clip = 1'b1;
        end else begin
            res_sat  = acc_q[dwcc_pkg::VAL_W-1:0];
            res_clip = 1'b0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en2) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && s2_valid_reg) begin
            m_out_channel_reg <= s2_ch_reg;
            m_filtered_reg    <= res_sat;
            m_clipped_reg     <= res_clip;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_out_channel_reg;
    assign m_filtered    = m_filtered_reg;
    assign m_clipped     = m_clipped_reg;

endmodule

// ===== rtl/dwcc_checker.sv =====
// port-level checker for the depthwise causal filter, bound to the top level
`include "assert_macros.svh"

module dwcc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [dwcc_pkg::CH_W-1:0]   m_out_channel,
    input logic signed [dwcc_pkg::VAL_W-1:0] m_filtered,
    input logic                        m_clipped
);

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_channel) && $stable(m_filtered) && $stable(m_clipped))

    // a clipped result sits at a rail
    `ASSERT_SAME(a_clip_rail, aclk, aresetn, m_valid && m_clipped, (m_filtered == 16'sh7fff) || (m_filtered == -16'sh8000))

    // requests back up only behind an undelivered result
    `ASSERT_SAME(a_ready_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // reset leaves no result pending
    `ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid && s_ready)

endmodule

bind depthwise_causal_conv1d dwcc_checker u_dwcc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_channel (m_out_channel),
    .m_filtered    (m_filtered),
    .m_clipped     (m_clipped)
);
